// ===== hdl/imdu_pkg.sv =====
// Shared types and constants for the iterative multiply/divide unit.
// No dependencies; every other file in the project imports this package.
package imdu_pkg;

  // Command codes carried by an input beat.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // Register offsets within the window.
  localparam logic [4:0] OFF_MCAND    = 5'h02;
  localparam logic [4:0] OFF_MUL_GO   = 5'h03;
  localparam logic [4:0] OFF_DVND_LO  = 5'h04;
  localparam logic [4:0] OFF_DVND_HI  = 5'h05;
  localparam logic [4:0] OFF_DIV_GO   = 5'h06;
  localparam logic [4:0] OFF_QUO_LO   = 5'h14;
  localparam logic [4:0] OFF_QUO_HI   = 5'h15;
  localparam logic [4:0] OFF_PROD_LO  = 5'h16;
  localparam logic [4:0] OFF_PROD_HI  = 5'h17;

  // Step counts and reset values of the operand registers.
  localparam logic [3:0]  MUL_STEPS      = 4'd8;
  localparam logic [4:0]  DIV_STEPS      = 5'd16;
  localparam logic [7:0]  BYTE_RST       = 8'hFF;
  localparam logic [15:0] DVND_RST       = 16'hFFFF;

  // One input beat.
  typedef struct packed {
    logic [1:0] command;
    logic [4:0] reg_offset;
    logic [7:0] write_data;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] read_data;
    logic       busy_res;
  } out_item_t;

endpackage

// ===== hdl/imdu_in_stage.sv =====
// Input register of the unit: holds one accepted beat until execution takes it.
// Depends on imdu_pkg for the input beat type.
module imdu_in_stage import imdu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     take,
  output logic     held_valid,
  output in_item_t held_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     accept;

  // The register can load whenever it is empty or its beat leaves this cycle.
  assign in_stall   = valid_r && !take;
  assign accept     = in_valid && !in_stall;
  assign valid_nxt  = accept || (valid_r && !take);
  assign held_valid = valid_r;
  assign held_item  = item_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

endmodule

// ===== hdl/imdu_exec.sv =====
// Register file and step logic: applies one beat to the state and forms its result.
// Depends on imdu_pkg for command codes, offsets and beat types.
module imdu_exec import imdu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  logic [7:0]  mcand_r,  mcand_nxt;
  logic [7:0]  mplier_r, mplier_nxt;
  logic [15:0] dvnd_r,   dvnd_nxt;
  logic [7:0]  dvsr_r,   dvsr_nxt;
  logic [15:0] quo_r,    quo_nxt;
  logic [15:0] prod_r,   prod_nxt;
  logic [23:0] term_r,   term_nxt;
  logic [3:0]  mul_cnt_r, mul_cnt_nxt;
  logic [4:0]  div_cnt_r, div_cnt_nxt;
  logic        busy;
  logic [7:0]  rd;
  logic [23:0] term_half;

  assign busy      = (mul_cnt_r != '0) || (div_cnt_r != '0);
  assign term_half = term_r >> 1;

  // Next state and read data for the beat under execution.
  always_comb begin
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    dvnd_nxt    = dvnd_r;
    dvsr_nxt    = dvsr_r;
    quo_nxt     = quo_r;
    prod_nxt    = prod_r;
    term_nxt    = term_r;
    mul_cnt_nxt = mul_cnt_r;
    div_cnt_nxt = div_cnt_r;
    rd          = '0;
    case (item.command)
      CMD_WRITE: begin
        case (item.reg_offset)
          OFF_MCAND: begin
            mcand_nxt = item.write_data;
          end
          OFF_MUL_GO: begin
            prod_nxt = '0;
            if (!busy) begin
              mplier_nxt  = item.write_data;
              quo_nxt     = {item.write_data, mcand_r};
              mul_cnt_nxt = MUL_STEPS;
              term_nxt    = {16'd0, item.write_data};
            end
          end
          OFF_DVND_LO: begin
            dvnd_nxt = {dvnd_r[15:8], item.write_data};
          end
          OFF_DVND_HI: begin
            dvnd_nxt = {item.write_data, dvnd_r[7:0]};
          end
          OFF_DIV_GO: begin
            prod_nxt = dvnd_r;
            if (!busy) begin
              dvsr_nxt    = item.write_data;
              div_cnt_nxt = DIV_STEPS;
              term_nxt    = {item.write_data, 16'd0};
            end
          end
          default: begin
          end
        endcase
      end
      CMD_READ: begin
        case (item.reg_offset)
          OFF_QUO_LO:  rd = quo_r[7:0];
          OFF_QUO_HI:  rd = quo_r[15:8];
          OFF_PROD_LO: rd = prod_r[7:0];
          OFF_PROD_HI: rd = prod_r[15:8];
          default:     rd = '0;
        endcase
      end
      CMD_TICK: begin
        // Only one operation can be running, so the two steps are exclusive.
        if (mul_cnt_r != '0) begin
          mul_cnt_nxt = mul_cnt_r - 4'd1;
          if (quo_r[0]) begin
            prod_nxt = prod_r + term_r[15:0];
          end
          quo_nxt  = quo_r >> 1;
          term_nxt = term_r << 1;
        end else if (div_cnt_r != '0) begin
          div_cnt_nxt = div_cnt_r - 5'd1;
          term_nxt    = term_half;
          if ({8'd0, prod_r} >= term_half) begin
            prod_nxt = prod_r - term_half[15:0];
            quo_nxt  = {quo_r[14:0], 1'b1};
          end else begin
            quo_nxt  = {quo_r[14:0], 1'b0};
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Busy is reported as it stands after the beat has taken effect.
  assign result.read_data = rd;
  assign result.busy_res  = (mul_cnt_nxt != '0) || (div_cnt_nxt != '0);

  // State registers, updated once per executed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcand_r   <= BYTE_RST;
      mplier_r  <= BYTE_RST;
      dvnd_r    <= DVND_RST;
      dvsr_r    <= BYTE_RST;
      quo_r     <= '0;
      prod_r    <= '0;
      term_r    <= '0;
      mul_cnt_r <= '0;
      div_cnt_r <= '0;
    end else if (fire) begin
      mcand_r   <= mcand_nxt;
      mplier_r  <= mplier_nxt;
      dvnd_r    <= dvnd_nxt;
      dvsr_r    <= dvsr_nxt;
      quo_r     <= quo_nxt;
      prod_r    <= prod_nxt;
      term_r    <= term_nxt;
      mul_cnt_r <= mul_cnt_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule

// ===== hdl/imdu_out_stage.sv =====
// Result register: holds one result beat until the consumer takes it.
// Depends on imdu_pkg for the result beat type.
module imdu_out_stage import imdu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_item,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  // A new result may enter when the register is empty or being drained.
  assign room      = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_data  = item_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

endmodule

// ===== hdl/iterative_multiply_divide_unit_top.sv =====
// Iterative multiply/divide unit: one result beat for every input beat.
// An accepted beat waits in the input register until the result register has room; the
// execute stage then applies it to the state and writes its result into the result register.
// Throughput is one beat per cycle when out_stall is low; a tick steps a running operation.
// Synchronous active-low reset empties both registers and loads the operand defaults.
// Depends on imdu_pkg, imdu_in_stage, imdu_exec and imdu_out_stage.
module iterative_multiply_divide_unit_top import imdu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      held_valid;
  in_item_t  held_item;
  logic      room;
  logic      fire;
  out_item_t result;

  // A held beat executes whenever the result register can take its result.
  assign fire = held_valid && room;

  imdu_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  imdu_exec u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (held_item),
    .result (result)
  );

  imdu_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .load_item (result),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
